// ===== rtl/core/s2d_pkg.sv =====
package s2d_pkg;

  localparam int VALUE_W     = 64;
  localparam int CHAR_W      = 6;
  localparam int NUM_DIGITS  = 20;
  localparam int BCD_W       = 4 * NUM_DIGITS;
  localparam int IDX_W       = $clog2(NUM_DIGITS);
  localparam int BIT_CNT_W   = $clog2(VALUE_W);
  localparam int QUEUE_DEPTH = 2;

  localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;
  localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;

  // one converted job between the front and the back
  typedef struct packed {
    logic               neg;
    logic [VALUE_W-1:0] mag;
  } work_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_SKIP,
    ST_SIGN,
    ST_DIGIT
  } back_state_t;

endpackage

// ===== rtl/core/s2d_front.sv =====
module s2d_front (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_push,
  input  logic signed [s2d_pkg::VALUE_W-1:0] in_value,
  output logic                              in_full,
  output logic                              q_push,
  output s2d_pkg::work_t                    q_data,
  input  logic                              q_full
);

  logic                               vld_r, vld_nxt;
  logic signed [s2d_pkg::VALUE_W-1:0] value_r;
  logic                               accept;

  assign in_full = vld_r && q_full;
  assign accept  = in_push && !in_full;
  assign q_push  = vld_r && !q_full;

  // sign split and unsigned magnitude, most negative value wraps to 2^63
  always_comb begin
    q_data.neg = value_r[s2d_pkg::VALUE_W-1];
    q_data.mag = q_data.neg ? (~$unsigned(value_r) + 1'b1) : $unsigned(value_r);
  end

  always_comb begin
    vld_nxt = vld_r;
    if (accept) begin
      vld_nxt = 1'b1;
    end else if (q_push) begin
      vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      value_r <= in_value;
    end
  end

endmodule

// ===== rtl/core/s2d_queue.sv =====
module s2d_queue #(
  parameter int DEPTH = s2d_pkg::QUEUE_DEPTH
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  s2d_pkg::work_t push_data,
  output logic           full,
  input  logic           pop,
  output s2d_pkg::work_t pop_data,
  output logic           empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  s2d_pkg::work_t   mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full     = (cnt_r == CNT_W'(DEPTH));
  assign empty    = (cnt_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  // occupancy rises by one on a push without a pop
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    (do_push && !do_pop) |=> (cnt_r == $past(cnt_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

// ===== rtl/core/s2d_back.sv =====
module s2d_back (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             q_empty,
  input  s2d_pkg::work_t                   q_data,
  output logic                             q_pop,
  input  logic                             out_pop,
  output logic                             out_empty,
  output logic [s2d_pkg::CHAR_W-1:0]       out_char_code,
  output logic                             out_last
);

  localparam int BW = s2d_pkg::BCD_W;
  localparam int VW = s2d_pkg::VALUE_W;
  localparam int IW = s2d_pkg::IDX_W;
  localparam int CW = s2d_pkg::BIT_CNT_W;

  s2d_pkg::back_state_t state_r, state_nxt;

  logic [VW-1:0]               bin_r, bin_nxt;
  logic [BW-1:0]               bcd_r, bcd_nxt, bcd_adj;
  logic [CW-1:0]               bit_cnt_r, bit_cnt_nxt;
  logic [IW-1:0]               idx_r, idx_nxt;
  logic                        neg_r, neg_nxt;
  logic                        out_vld_r, out_vld_nxt;
  logic [s2d_pkg::CHAR_W-1:0]  out_char_r, out_char_nxt;
  logic                        out_last_r, out_last_nxt;
  logic [3:0]                  cur_digit;
  logic                        can_emit;
  logic                        emit;
  logic                        conv_done;

  assign out_empty     = !out_vld_r;
  assign out_char_code = out_char_r;
  assign out_last      = out_last_r;
  assign can_emit      = !out_vld_r || out_pop;
  assign cur_digit     = bcd_r[{idx_r, 2'b00} +: 4];
  assign conv_done     = (bit_cnt_r == CW'(VW - 1));

  // add-3 correction on every digit before the shift
  always_comb begin
    bcd_adj = bcd_r;
    for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_r[4*i +: 4] + 4'd3;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      s2d_pkg::ST_IDLE: begin
        if (!q_empty) begin
          state_nxt = s2d_pkg::ST_CONV;
        end
      end
      s2d_pkg::ST_CONV: begin
        if (conv_done) begin
          state_nxt = s2d_pkg::ST_SKIP;
        end
      end
      s2d_pkg::ST_SKIP: begin
        if (cur_digit != 4'd0 || idx_r == '0) begin
          state_nxt = neg_r ? s2d_pkg::ST_SIGN : s2d_pkg::ST_DIGIT;
        end
      end
      s2d_pkg::ST_SIGN: begin
        if (can_emit) begin
          state_nxt = s2d_pkg::ST_DIGIT;
        end
      end
      s2d_pkg::ST_DIGIT: begin
        if (can_emit && idx_r == '0) begin
          state_nxt = s2d_pkg::ST_IDLE;
        end
      end
      default: state_nxt = s2d_pkg::ST_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    q_pop        = 1'b0;
    emit         = 1'b0;
    bin_nxt      = bin_r;
    bcd_nxt      = bcd_r;
    bit_cnt_nxt  = bit_cnt_r;
    idx_nxt      = idx_r;
    neg_nxt      = neg_r;
    out_char_nxt = out_char_r;
    out_last_nxt = out_last_r;
    case (state_r)
      s2d_pkg::ST_IDLE: begin
        if (!q_empty) begin
          q_pop       = 1'b1;
          bin_nxt     = q_data.mag;
          neg_nxt     = q_data.neg;
          bcd_nxt     = '0;
          bit_cnt_nxt = '0;
        end
      end
      s2d_pkg::ST_CONV: begin
        bcd_nxt     = {bcd_adj[BW-2:0], bin_r[VW-1]};
        bin_nxt     = {bin_r[VW-2:0], 1'b0};
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        idx_nxt     = IW'(s2d_pkg::NUM_DIGITS - 1);
      end
      s2d_pkg::ST_SKIP: begin
        if (cur_digit == 4'd0 && idx_r != '0) begin
          idx_nxt = idx_r - 1'b1;
        end
      end
      s2d_pkg::ST_SIGN: begin
        if (can_emit) begin
          emit         = 1'b1;
          out_char_nxt = s2d_pkg::CH_MINUS;
          out_last_nxt = 1'b0;
        end
      end
      s2d_pkg::ST_DIGIT: begin
        if (can_emit) begin
          emit         = 1'b1;
          out_char_nxt = s2d_pkg::CH_ZERO + {2'b00, cur_digit};
          out_last_nxt = (idx_r == '0);
          if (idx_r != '0) begin
            idx_nxt = idx_r - 1'b1;
          end
        end
      end
      default: ;
    endcase
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_pop) begin
      out_vld_nxt = 1'b0;
    end else begin
      out_vld_nxt = out_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= s2d_pkg::ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bin_r      <= bin_nxt;
    bcd_r      <= bcd_nxt;
    bit_cnt_r  <= bit_cnt_nxt;
    idx_r      <= idx_nxt;
    neg_r      <= neg_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

  // a new job is taken only when the previous one is fully emitted
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (state_r == s2d_pkg::ST_IDLE))
    else $error("job popped while busy");

  // conversion runs its full bit count without leaving
  a_conv_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == s2d_pkg::ST_CONV && !conv_done) |=> (state_r == s2d_pkg::ST_CONV))
    else $error("conversion left early");

  // leading-zero skip stops on a nonzero digit or the units digit
  a_skip_stop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == s2d_pkg::ST_SKIP && state_nxt != s2d_pkg::ST_SKIP)
      |-> (cur_digit != 4'd0 || idx_r == '0))
    else $error("skip ended on a leading zero");

  // the minus sign is always followed by digit output
  a_sign_then_digit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == s2d_pkg::ST_SIGN && emit) |=> (state_r == s2d_pkg::ST_DIGIT))
    else $error("minus sign not followed by digits");

endmodule

// ===== rtl/core/signed_binary_to_decimal_ascii.sv =====
// a value is registered in the front and queued; the engine then converts one value at
//   a time by the 64-step bit-serial shift-add-3 loop, a one-digit-per-cycle
//   leading-zero scan (shorter for longer numbers, so the first character comes sooner)
//   and digit output, one per cycle unless out_pop stalls; the queue fills meanwhile
// reset: synchronous active-low rst_n clears the queue and front, engine goes idle
module signed_binary_to_decimal_ascii #(
  parameter int QUEUE_DEPTH = s2d_pkg::QUEUE_DEPTH
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // input channel, one signed value per transaction
  input  logic                               in_push,
  input  logic signed [s2d_pkg::VALUE_W-1:0] in_value,
  output logic                               in_full,
  // result channel, one character per transaction
  input  logic                               out_pop,
  output logic                               out_empty,
  output logic [s2d_pkg::CHAR_W-1:0]         out_char_code,
  output logic                               out_last
);

  // front to queue
  logic           fq_push;
  s2d_pkg::work_t fq_data;
  logic           fq_full;

  // queue to back
  logic           qb_pop;
  s2d_pkg::work_t qb_data;
  logic           qb_empty;

  // front: registers the value, splits sign and forms the unsigned magnitude
  s2d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_value (in_value),
    .in_full  (in_full),
    .q_push   (fq_push),
    .q_data   (fq_data),
    .q_full   (fq_full)
  );

  // short job queue so the front keeps taking values while the back converts
  s2d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (fq_push),
    .push_data (fq_data),
    .full      (fq_full),
    .pop       (qb_pop),
    .pop_data  (qb_data),
    .empty     (qb_empty)
  );

  // back: binary to bcd, leading-zero skip, then sign and digits
  // through a registered output stage
  s2d_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (qb_empty),
    .q_data        (qb_data),
    .q_pop         (qb_pop),
    .out_pop       (out_pop),
    .out_empty     (out_empty),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule

// ===== test/signed_binary_to_decimal_ascii_tb.sv =====
`timescale 1ns / 1ps

module signed_binary_to_decimal_ascii_tb;

  localparam int CLK_PERIOD     = 8;
  localparam int RANDOM_PER_SET = 47;
  localparam int BURST_VALUES   = 12;
  localparam int RX_HOLD_CYCLES = 600;
  localparam int SETTLE_CYCLES  = 150;
  localparam int RUN_LIMIT_NS   = 8_000_000;

  // one character of rendered text as it leaves the block
  typedef struct packed {
    logic [s2d_pkg::CHAR_W-1:0] code;
    logic                       last;
  } text_char_t;

  logic                               clk = 1'b0;
  logic                               rst_n = 1'b0;
  logic                               in_push = 1'b0;
  logic signed [s2d_pkg::VALUE_W-1:0] in_value = '0;
  logic                               in_full;
  logic                               out_pop = 1'b0;
  logic                               out_empty;
  logic [s2d_pkg::CHAR_W-1:0]         out_char_code;
  logic                               out_last;

  // values waiting to be offered, and the characters they must turn into
  logic signed [s2d_pkg::VALUE_W-1:0] pending_values[$];
  text_char_t                         expected_chars[$];

  // idle and stall chances in percent, changed only on the falling edge
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  // receiver hold-off: the stimulus bumps the request count, the monitor counts it out
  int hold_requests = 0;
  int hold_seen = 0;
  int hold_left = 0;

  int mismatch_count = 0;

  signed_binary_to_decimal_ascii uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_push      (in_push),
    .in_value     (in_value),
    .in_full      (in_full),
    .out_pop      (out_pop),
    .out_empty    (out_empty),
    .out_char_code(out_char_code),
    .out_last     (out_last)
  );

  initial begin
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // decimal text of one value: optional minus, then digits msd first, last on the final one
  function automatic void predict_decimal_chars(logic signed [s2d_pkg::VALUE_W-1:0] value);
    logic [s2d_pkg::VALUE_W-1:0] magnitude;
    logic [3:0]                  digits [s2d_pkg::NUM_DIGITS];
    int                          count;
    text_char_t                  ch;
    magnitude = value;
    // plain unsigned negation, so the most negative value needs no special path
    if (value[s2d_pkg::VALUE_W-1]) magnitude = ~magnitude + 64'd1;
    count = 0;
    while (count == 0 || magnitude != 0) begin
      digits[count] = 4'(magnitude % 64'd10);
      magnitude = magnitude / 64'd10;
      count++;
    end
    if (value[s2d_pkg::VALUE_W-1]) begin
      ch.code = s2d_pkg::CH_MINUS;
      ch.last = 1'b0;
      expected_chars.push_back(ch);
    end
    for (int k = count - 1; k >= 0; k--) begin
      ch.code = s2d_pkg::CH_ZERO + s2d_pkg::CHAR_W'(digits[k]);
      ch.last = (k == 0);
      expected_chars.push_back(ch);
    end
  endfunction

  // mix of full-range words, n-digit values, powers of ten and their neighbors, small values
  function automatic logic signed [s2d_pkg::VALUE_W-1:0] draw_value();
    logic [s2d_pkg::VALUE_W-1:0] raw;
    logic [s2d_pkg::VALUE_W-1:0] scale;
    int                          digit_count;
    raw = {$urandom, $urandom};
    scale = 64'd1;
    digit_count = $urandom_range(1, 19);
    repeat (digit_count) scale = scale * 64'd10;
    case ($urandom_range(0, 3))
      0: return raw;
      1: raw = raw % scale;
      2: raw = scale + 64'($urandom_range(0, 2)) - 64'd1;
      default: raw = 64'($urandom_range(0, 99));
    endcase
    if ($urandom_range(0, 1) == 1) raw = ~raw + 64'd1;
    return raw;
  endfunction

  // driver: a transaction completes on an edge with push high and full low
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else if (!in_push || !in_full) begin
      if (in_push) predict_decimal_chars(in_value);
      if (pending_values.size() != 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
        in_push  <= 1'b1;
        in_value <= pending_values.pop_front();
      end else begin
        // junk on the data port while idle, the block must ignore it
        in_push  <= 1'b0;
        in_value <= {$urandom, $urandom};
      end
    end
  end

  // monitor: checks every popped character against the oldest expected one
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (expected_chars.size() == 0) begin
          $error("unexpected character: char_code %0d last %0d", out_char_code, out_last);
          mismatch_count++;
        end else begin
          text_char_t want;
          want = expected_chars.pop_front();
          if (out_char_code !== want.code) begin
            $error("char_code mismatch: expected %0d, got %0d", want.code, out_char_code);
            mismatch_count++;
          end
          if (out_last !== want.last) begin
            $error("last mismatch: expected %0d, got %0d", want.last, out_last);
            mismatch_count++;
          end
        end
      end
      if (hold_seen != hold_requests) begin
        hold_seen = hold_requests;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= ($urandom_range(0, 99) >= rx_stall_pct);
      end
    end
  end

  // sender stays quiet until every queued value went in and all its text came out
  task automatic wait_for_drain();
    while (pending_values.size() != 0 || in_push || expected_chars.size() != 0)
      @(negedge clk);
  endtask

  task automatic queue_random_values(int count);
    repeat (count) pending_values.push_back(draw_value());
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // corners: zero, single digits, digit-count boundaries, both extremes, bit patterns
    pending_values.push_back(64'sd0);
    pending_values.push_back(64'sd1);
    pending_values.push_back(-64'sd1);
    pending_values.push_back(64'sd9);
    pending_values.push_back(-64'sd9);
    pending_values.push_back(64'sd10);
    pending_values.push_back(-64'sd10);
    pending_values.push_back(64'sd99);
    pending_values.push_back(64'sd100);
    pending_values.push_back(-64'sd100);
    pending_values.push_back(64'sd1234567890);
    pending_values.push_back(-64'sd1234567890);
    pending_values.push_back(64'sd999999999999999999);
    pending_values.push_back(64'sd1000000000000000000);
    pending_values.push_back(-64'sd1000000000000000000);
    pending_values.push_back(64'h7FFF_FFFF_FFFF_FFFF);
    pending_values.push_back(64'h8000_0000_0000_0000);
    pending_values.push_back(64'h8000_0000_0000_0001);
    pending_values.push_back(64'hAAAA_AAAA_AAAA_AAAA);
    pending_values.push_back(64'h5555_5555_5555_5555);
    wait_for_drain();

    // receiver holds off while the sender keeps offering, so the input backs up
    queue_random_values(BURST_VALUES);
    hold_requests++;
    wait_for_drain();

    // no idling, sender idle, receiver stalling, both
    for (int set = 0; set < 4; set++) begin
      case (set)
        0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        1: begin tx_idle_pct = 59; rx_stall_pct = 0;  end
        2: begin tx_idle_pct = 0;  rx_stall_pct = 59; end
        default: begin tx_idle_pct = 32; rx_stall_pct = 32; end
      endcase
      queue_random_values(RANDOM_PER_SET);
      wait_for_drain();
    end

    // anything popped from here on is a stray character
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
